// File: rtl/wesp_pkg.sv
// Shared types, constants and helpers of the export section parser.
`default_nettype none
package wesp_pkg;

	localparam int MAX_EXPORTS = 16;
	localparam int NAME_KEEP   = 31;

	localparam logic [31:0] MAGIC     = 32'h6d736100;
	localparam logic [7:0]  EXPORT_ID = 8'd7;

	localparam int HEADER_LEN = 8;
	localparam int MAGIC_LEN  = 4;
	localparam int LEB_MAX    = 5;

	localparam int HDR_W  = $clog2(HEADER_LEN + 1);
	localparam int SLOT_W = $clog2(MAX_EXPORTS + 1);
	localparam int NAME_W = $clog2(NAME_KEEP + 1);

	localparam int SLOT_OUT_W = 4;
	localparam int POS_OUT_W  = 5;
	localparam int LEN_OUT_W  = 5;
	localparam int CNT_OUT_W  = 5;

	typedef enum logic [2:0] {
		PH_SECID,
		PH_SECSIZE,
		PH_COUNT,
		PH_NAMELEN,
		PH_NAME,
		PH_KIND,
		PH_INDEX,
		PH_SKIP
	} phase_t;

	typedef enum logic [2:0] {
		EV_CHAR     = 3'd0,
		EV_DONE     = 3'd1,
		EV_OK       = 3'd2,
		EV_BADMAGIC = 3'd3,
		EV_SHORT    = 3'd4,
		EV_TRUNC    = 3'd5
	} ev_t;

	typedef struct packed {
		logic [HDR_W-1:0]  header_pos;
		logic              magic_ok;
		phase_t            phase;
		logic [7:0]        section_kind;
		logic [31:0]       section_left;
		logic [31:0]       leb_value;
		logic [2:0]        leb_bytes;
		logic [SLOT_W-1:0] exports_wanted;
		logic [SLOT_W-1:0] current_slot;
		logic [31:0]       name_left;
		logic [NAME_W-1:0] name_pos;
		logic [SLOT_W-1:0] recorded_count;
	} st_t;

	localparam st_t ST_RESET = '{
		header_pos:     '0,
		magic_ok:       1'b1,
		phase:          PH_SECID,
		section_kind:   '0,
		section_left:   '0,
		leb_value:      '0,
		leb_bytes:      '0,
		exports_wanted: '0,
		current_slot:   '0,
		name_left:      '0,
		name_pos:       '0,
		recorded_count: '0
	};

	typedef struct packed {
		ev_t                  event_res;
		logic [SLOT_OUT_W-1:0] slot;
		logic [POS_OUT_W-1:0]  char_pos;
		logic [7:0]            name_char;
		logic [31:0]           func_index;
		logic [LEN_OUT_W-1:0]  name_length;
		logic [CNT_OUT_W-1:0]  exports_recorded;
		logic                  last_of_run;
	} res_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] pos);
		return MAGIC[8*pos +: 8];
	endfunction

endpackage
`default_nettype wire

// File: rtl/wesp_step.sv
// Next-state and result logic of the parser for one module byte.
`default_nettype none
module wesp_step (
	input  wire wesp_pkg::st_t st,
	input  wire logic [7:0]    data_byte,
	input  wire logic          last_byte,
	output wesp_pkg::st_t      nxt,
	output wesp_pkg::res_t     prim,
	output logic               prim_vld,
	output wesp_pkg::res_t     stat
);

	logic [31:0] leb_acc;
	logic [2:0]  leb_cnt;
	logic        leb_done;

	// Accumulate seven bits per byte; bits past 32 and bytes past the fifth drop out.
	always_comb begin
		leb_acc = st.leb_value;
		unique case (st.leb_bytes)
			3'd0:    leb_acc = st.leb_value | {25'd0, data_byte[6:0]};
			3'd1:    leb_acc = st.leb_value | {18'd0, data_byte[6:0], 7'd0};
			3'd2:    leb_acc = st.leb_value | {11'd0, data_byte[6:0], 14'd0};
			3'd3:    leb_acc = st.leb_value | {4'd0, data_byte[6:0], 21'd0};
			3'd4:    leb_acc = st.leb_value | {data_byte[3:0], 28'd0};
			default: leb_acc = st.leb_value;
		endcase
		leb_cnt  = (st.leb_bytes < 3'(wesp_pkg::LEB_MAX)) ? st.leb_bytes + 3'd1 : st.leb_bytes;
		leb_done = !data_byte[7];
	end

	always_comb begin
		nxt      = st;
		prim     = '0;
		prim_vld = 1'b0;
		stat     = '0;

		if (st.header_pos != wesp_pkg::HDR_W'(wesp_pkg::HEADER_LEN)) begin
			if (st.header_pos < wesp_pkg::HDR_W'(wesp_pkg::MAGIC_LEN) &&
			    data_byte != wesp_pkg::magic_byte(st.header_pos[1:0]))
				nxt.magic_ok = 1'b0;
			nxt.header_pos = st.header_pos + 1'b1;
			if (nxt.header_pos == wesp_pkg::HDR_W'(wesp_pkg::HEADER_LEN))
				nxt.phase = wesp_pkg::PH_SECID;
		end else if (st.magic_ok) begin
			if (st.phase == wesp_pkg::PH_SECID) begin
				nxt.section_kind = data_byte;
				nxt.phase        = wesp_pkg::PH_SECSIZE;
				nxt.leb_value    = '0;
				nxt.leb_bytes    = '0;
			end else if (st.phase == wesp_pkg::PH_SECSIZE) begin
				nxt.leb_value = leb_acc;
				nxt.leb_bytes = leb_cnt;
				if (leb_done) begin
					nxt.leb_value    = '0;
					nxt.leb_bytes    = '0;
					nxt.section_left = leb_acc;
					if (leb_acc == 32'd0) begin
						nxt.phase = wesp_pkg::PH_SECID;
					end else if (st.section_kind == wesp_pkg::EXPORT_ID) begin
						nxt.phase          = wesp_pkg::PH_COUNT;
						nxt.current_slot   = '0;
						nxt.recorded_count = '0;
					end else begin
						nxt.phase = wesp_pkg::PH_SKIP;
					end
				end
			end else begin
				unique case (st.phase)
					wesp_pkg::PH_COUNT: begin
						nxt.leb_value = leb_acc;
						nxt.leb_bytes = leb_cnt;
						if (leb_done) begin
							nxt.leb_value = '0;
							nxt.leb_bytes = '0;
							nxt.exports_wanted =
								(leb_acc < 32'(wesp_pkg::MAX_EXPORTS)) ?
								leb_acc[wesp_pkg::SLOT_W-1:0] :
								wesp_pkg::SLOT_W'(wesp_pkg::MAX_EXPORTS);
							nxt.phase = (nxt.exports_wanted != '0) ?
								wesp_pkg::PH_NAMELEN : wesp_pkg::PH_SKIP;
						end
					end
					wesp_pkg::PH_NAMELEN: begin
						nxt.leb_value = leb_acc;
						nxt.leb_bytes = leb_cnt;
						if (leb_done) begin
							nxt.leb_value = '0;
							nxt.leb_bytes = '0;
							nxt.name_left = leb_acc;
							nxt.name_pos  = '0;
							nxt.phase     = (leb_acc != 32'd0) ?
								wesp_pkg::PH_NAME : wesp_pkg::PH_KIND;
						end
					end
					wesp_pkg::PH_NAME: begin
						if (st.name_pos < wesp_pkg::NAME_W'(wesp_pkg::NAME_KEEP)) begin
							prim_vld       = 1'b1;
							prim.event_res = wesp_pkg::EV_CHAR;
							prim.slot      = st.current_slot[wesp_pkg::SLOT_OUT_W-1:0];
							prim.char_pos  = wesp_pkg::POS_OUT_W'(st.name_pos);
							prim.name_char = data_byte;
							nxt.name_pos   = st.name_pos + 1'b1;
						end
						nxt.name_left = st.name_left - 32'd1;
						if (st.name_left == 32'd1)
							nxt.phase = wesp_pkg::PH_KIND;
					end
					wesp_pkg::PH_KIND: begin
						nxt.phase = wesp_pkg::PH_INDEX;
					end
					wesp_pkg::PH_INDEX: begin
						nxt.leb_value = leb_acc;
						nxt.leb_bytes = leb_cnt;
						if (leb_done) begin
							nxt.leb_value    = '0;
							nxt.leb_bytes    = '0;
							prim_vld         = 1'b1;
							prim.event_res   = wesp_pkg::EV_DONE;
							prim.slot        = st.current_slot[wesp_pkg::SLOT_OUT_W-1:0];
							prim.func_index  = leb_acc;
							prim.name_length = wesp_pkg::LEN_OUT_W'(st.name_pos);
							if (st.recorded_count < wesp_pkg::SLOT_W'(wesp_pkg::MAX_EXPORTS))
								nxt.recorded_count = st.recorded_count + 1'b1;
							nxt.current_slot = st.current_slot + 1'b1;
							nxt.phase = (nxt.current_slot >= st.exports_wanted) ?
								wesp_pkg::PH_SKIP : wesp_pkg::PH_NAMELEN;
						end
					end
					default: ;
				endcase
				// Every body byte counts against the section; leave at its end.
				nxt.section_left = st.section_left - 32'd1;
				if (st.section_left == 32'd1) begin
					nxt.phase     = wesp_pkg::PH_SECID;
					nxt.leb_value = '0;
					nxt.leb_bytes = '0;
				end
			end
		end

		prim.last_of_run = !last_byte;

		priority if (nxt.header_pos != wesp_pkg::HDR_W'(wesp_pkg::HEADER_LEN))
			stat.event_res = wesp_pkg::EV_SHORT;
		else if (!nxt.magic_ok)
			stat.event_res = wesp_pkg::EV_BADMAGIC;
		else if (nxt.phase == wesp_pkg::PH_SECID)
			stat.event_res = wesp_pkg::EV_OK;
		else
			stat.event_res = wesp_pkg::EV_TRUNC;
		stat.exports_recorded = wesp_pkg::CNT_OUT_W'(nxt.recorded_count);
		stat.last_of_run      = 1'b1;

		// The final byte closes the module: start afresh.
		if (last_byte)
			nxt = wesp_pkg::ST_RESET;
	end

endmodule
`default_nettype wire

// File: rtl/wasm_export_section_parser.sv
// Top level of the WebAssembly export section parser.
// Takes one module byte per cycle while src_stall is low and walks the header and
// sections in a single pass of logic between the parse state registers and a
// result register. A byte gives at most one name-character or export-done event;
// the byte flagged last_byte also gives a status event (ok, bad magic, too short,
// truncated) and returns the parser to its reset state. A byte's first result
// leaves in the cycle after the byte is taken. A final byte that also carries an
// event gives two results, so src_stall is raised while the second result waits
// in the spill register behind the output register, and while res_stall holds
// a waiting result. The result port holds its transaction while res_stall is high.
`default_nettype none
module wasm_export_section_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        src_valid,
	output logic             src_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic [2:0]       event_res,
	output logic [3:0]       slot,
	output logic [4:0]       char_pos,
	output logic [7:0]       name_char,
	output logic [31:0]      func_index,
	output logic [4:0]       name_length,
	output logic [4:0]       exports_recorded,
	output logic             last_of_run
);

	wesp_pkg::st_t  st_q;
	wesp_pkg::st_t  st_nxt;
	wesp_pkg::res_t prim;
	wesp_pkg::res_t stat;
	logic           prim_vld;

	wesp_pkg::res_t out_q;
	wesp_pkg::res_t ext_q;
	logic           out_vld_q;
	logic           ext_vld_q;
	logic           accept;
	logic           out_free;

	wesp_step u_step (
		.st        (st_q),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.nxt       (st_nxt),
		.prim      (prim),
		.prim_vld  (prim_vld),
		.stat      (stat)
	);

	assign src_stall = out_vld_q && (res_stall || ext_vld_q);
	assign accept    = src_valid && !src_stall;
	assign out_free  = !out_vld_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= wesp_pkg::ST_RESET;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			ext_vld_q <= 1'b0;
		end else if (out_free) begin
			if (ext_vld_q) begin
				out_vld_q <= 1'b1;
				ext_vld_q <= 1'b0;
			end else if (accept) begin
				out_vld_q <= prim_vld || last_byte;
				ext_vld_q <= prim_vld && last_byte;
			end else begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Event first, status behind it in the spill register.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (ext_vld_q)
				out_q <= ext_q;
			else if (accept)
				out_q <= prim_vld ? prim : stat;
			if (accept)
				ext_q <= stat;
		end
	end

	assign res_valid        = out_vld_q;
	assign event_res        = out_q.event_res;
	assign slot             = out_q.slot;
	assign char_pos         = out_q.char_pos;
	assign name_char        = out_q.name_char;
	assign func_index       = out_q.func_index;
	assign name_length      = out_q.name_length;
	assign exports_recorded = out_q.exports_recorded;
	assign last_of_run      = out_q.last_of_run;

endmodule
`default_nettype wire
